// ===== hdl/cau_pkg.sv =====
// Opcodes shared by the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_CMP  = 4'd4,
        OP_MOD  = 4'd5,
        OP_CONJ = 4'd6,
        OP_INC  = 4'd7,
        OP_DEC  = 4'd8
    } op_t;

endpackage

// ===== hdl/cau_step.sv =====
// One radix-2 step of the two fraction dividers and the square root.
module cau_step
    import cau_pkg::*;
#(
    parameter int PART_WIDTH = 16
) (
    input  logic [2*PART_WIDTH-1:0] den,
    input  logic [2*PART_WIDTH-1:0] rem_r_in,
    input  logic [PART_WIDTH-1:0]   q_r_in,
    input  logic                    bit_r,
    input  logic [2*PART_WIDTH-1:0] rem_i_in,
    input  logic [PART_WIDTH-1:0]   q_i_in,
    input  logic                    bit_i,
    input  logic [PART_WIDTH+1:0]   srem_in,
    input  logic [PART_WIDTH-1:0]   sq_in,
    input  logic [1:0]              pair,
    output logic [2*PART_WIDTH-1:0] rem_r_out,
    output logic [PART_WIDTH-1:0]   q_r_out,
    output logic [2*PART_WIDTH-1:0] rem_i_out,
    output logic [PART_WIDTH-1:0]   q_i_out,
    output logic [PART_WIDTH+1:0]   srem_out,
    output logic [PART_WIDTH-1:0]   sq_out
);

    localparam int W  = PART_WIDTH;
    localparam int MW = 2 * W;

    logic [MW:0]  t_r;
    logic [MW:0]  t_i;
    logic [MW:0]  d_x;
    logic [W+3:0] t_s;
    logic [W+3:0] trial;

    assign d_x   = {1'b0, den};
    assign t_r   = {rem_r_in, bit_r};
    assign t_i   = {rem_i_in, bit_i};
    assign t_s   = {srem_in, pair};
    assign trial = {2'b00, sq_in, 2'b01};

    always_comb
    begin
        if (t_r >= d_x)
        begin
            rem_r_out = MW'(t_r - d_x);
            q_r_out   = {q_r_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_r_out = t_r[MW-1:0];
            q_r_out   = {q_r_in[W-2:0], 1'b0};
        end

        if (t_i >= d_x)
        begin
            rem_i_out = MW'(t_i - d_x);
            q_i_out   = {q_i_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_i_out = t_i[MW-1:0];
            q_i_out   = {q_i_in[W-2:0], 1'b0};
        end

        // restoring root: subtract 4q+1 when it fits
        if (t_s >= trial)
        begin
            srem_out = (W+2)'(t_s - trial);
            sq_out   = {sq_in[W-2:0], 1'b1};
        end
        else
        begin
            srem_out = t_s[W+1:0];
            sq_out   = {sq_in[W-2:0], 1'b0};
        end
    end

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// A start beat passes the capture, product, cross-sum and set-up stages, the radix-2 steps and the result register.
// Throughput: one beat per cycle; busy is held low, the pipeline never stalls.
// Depth is set by the PART_WIDTH radix-2 steps shared by divide and square root.
// Reset clears the valid bits only; no result is shown until a beat has passed through.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int PART_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   op,
    input  logic signed [PART_WIDTH-1:0] a_re,
    input  logic signed [PART_WIDTH-1:0] a_im,
    input  logic signed [PART_WIDTH-1:0] b_re,
    input  logic signed [PART_WIDTH-1:0] b_im,
    output logic                         done,
    output logic signed [PART_WIDTH-1:0] res_re,
    output logic signed [PART_WIDTH-1:0] res_im,
    output logic                         mag_less,
    output logic                         mag_greater,
    output logic                         mag_equal,
    output logic                         exact_equal,
    output logic                         divide_by_zero,
    output logic                         saturated
);

    localparam int W   = PART_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int MW  = 2 * W;
    localparam int SMW = MW + 1;
    localparam int EW  = W + F + 2;
    localparam int NW  = MW + F;
    localparam int CW  = MW + F + W;

    typedef struct packed {
        op_t           op;
        logic          neg_r;
        logic          neg_i;
        logic [MW-1:0] mag_r;
        logic [MW-1:0] mag_i;
        logic [MW-1:0] den;
        logic [MW-1:0] mag_a;
        logic [W-1:0]  s_re;
        logic [W-1:0]  s_im;
        logic          s_sat;
        logic          s_ex;
    } side_t;

    typedef struct packed {
        logic [MW-1:0] rem_r;
        logic [MW-1:0] rem_i;
        logic [W-1:0]  q_r;
        logic [W-1:0]  q_i;
        logic [W-1:0]  sq;
        logic [W+1:0]  srem;
    } iter_t;

    function automatic logic [W:0] clamp_int(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        hi = $signed({{(EW-W+1){1'b0}}, {(W-1){1'b1}}});
        lo = $signed({{(EW-W+1){1'b1}}, {(W-1){1'b0}}});
        if (v > hi)
            return {1'b1, hi[W-1:0]};
        else if (v < lo)
            return {1'b1, lo[W-1:0]};
        else
            return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W:0] clamp_sm(input logic neg, input logic [MW:0] m);
        logic [MW:0] half;
        logic [MW:0] hm1;
        logic [MW:0] nm;
        half = {{(MW+1-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
        hm1  = half - 1'b1;
        nm   = ~m + 1'b1;
        if (neg)
        begin
            if (m > half)
                return {1'b1, half[W-1:0]};
            else
                return {1'b0, nm[W-1:0]};
        end
        else if (m > hm1)
            return {1'b1, hm1[W-1:0]};
        else
            return {1'b0, m[W-1:0]};
    endfunction

    assign busy = 1'b0;

    // stage 1: operand capture
    logic                v1_reg;
    op_t                 op1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= op_t'(op);
        ar1_reg <= a_re;
        ai1_reg <= a_im;
        br1_reg <= b_re;
        bi1_reg <= b_im;
    end

    // stage 2: products, and the ops that need none
    logic signed [EW-1:0] ar_x, ai_x, br_x, bi_x, one_x;
    logic [W:0]           sr_c, si_c;
    logic [W-1:0]         s_re_next, s_im_next;
    logic                 s_sat_next, s_ex_next;

    logic                 v2_reg;
    op_t                  op2_reg;
    logic signed [MW-1:0] p_arbr_reg, p_aibi_reg, p_arbi_reg, p_aibr_reg;
    logic signed [MW-1:0] q_ar_reg, q_ai_reg, q_br_reg, q_bi_reg;
    logic [W-1:0]         s_re2_reg, s_im2_reg;
    logic                 s_sat2_reg, s_ex2_reg;

    assign ar_x  = EW'(ar1_reg);
    assign ai_x  = EW'(ai1_reg);
    assign br_x  = EW'(br1_reg);
    assign bi_x  = EW'(bi1_reg);
    assign one_x = $signed(EW'(1) << F);

    always_comb
    begin
        sr_c       = '0;
        si_c       = '0;
        s_re_next  = '0;
        s_im_next  = '0;
        s_sat_next = 1'b0;
        s_ex_next  = 1'b0;
        case (op1_reg)
            OP_ADD:
            begin
                sr_c = clamp_int(ar_x + br_x);
                si_c = clamp_int(ai_x + bi_x);
            end
            OP_SUB:
            begin
                sr_c = clamp_int(ar_x - br_x);
                si_c = clamp_int(ai_x - bi_x);
            end
            OP_CONJ:
            begin
                sr_c = {1'b0, ar1_reg};
                si_c = clamp_int(-ai_x);
            end
            OP_INC:
            begin
                sr_c = clamp_int(ar_x + one_x);
                si_c = {1'b0, ai1_reg};
            end
            OP_DEC:
            begin
                sr_c = clamp_int(ar_x - one_x);
                si_c = {1'b0, ai1_reg};
            end
            OP_CMP:
                s_ex_next = (ar1_reg == br1_reg) && (ai1_reg == bi1_reg);
            default:
            begin
            end
        endcase
        s_re_next  = sr_c[W-1:0];
        s_im_next  = si_c[W-1:0];
        s_sat_next = sr_c[W] | si_c[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        op2_reg    <= op1_reg;
        p_arbr_reg <= ar1_reg * br1_reg;
        p_aibi_reg <= ai1_reg * bi1_reg;
        p_arbi_reg <= ar1_reg * bi1_reg;
        p_aibr_reg <= ai1_reg * br1_reg;
        q_ar_reg   <= ar1_reg * ar1_reg;
        q_ai_reg   <= ai1_reg * ai1_reg;
        q_br_reg   <= br1_reg * br1_reg;
        q_bi_reg   <= bi1_reg * bi1_reg;
        s_re2_reg  <= s_re_next;
        s_im2_reg  <= s_im_next;
        s_sat2_reg <= s_sat_next;
        s_ex2_reg  <= s_ex_next;
    end

    // stage 3: cross sums and squared magnitudes
    logic signed [SMW-1:0] n_re_next, n_im_next;
    logic [MW-1:0]         maga_next, magb_next;

    logic                  v3_reg;
    op_t                   op3_reg;
    logic signed [SMW-1:0] n_re3_reg, n_im3_reg;
    logic [MW-1:0]         maga3_reg, magb3_reg;
    logic [W-1:0]          s_re3_reg, s_im3_reg;
    logic                  s_sat3_reg, s_ex3_reg;

    always_comb
    begin
        if (op2_reg == OP_MUL)
        begin
            n_re_next = SMW'(p_arbr_reg) - SMW'(p_aibi_reg);
            n_im_next = SMW'(p_arbi_reg) + SMW'(p_aibr_reg);
        end
        else
        begin
            n_re_next = SMW'(p_arbr_reg) + SMW'(p_aibi_reg);
            n_im_next = SMW'(p_aibr_reg) - SMW'(p_arbi_reg);
        end
        maga_next = $unsigned(q_ar_reg) + $unsigned(q_ai_reg);
        magb_next = $unsigned(q_br_reg) + $unsigned(q_bi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        op3_reg    <= op2_reg;
        n_re3_reg  <= n_re_next;
        n_im3_reg  <= n_im_next;
        maga3_reg  <= maga_next;
        magb3_reg  <= magb_next;
        s_re3_reg  <= s_re2_reg;
        s_im3_reg  <= s_im2_reg;
        s_sat3_reg <= s_sat2_reg;
        s_ex3_reg  <= s_ex2_reg;
    end

    // stage 4: sign and magnitude, divider and root set-up
    side_t           side_next;
    iter_t           iter_next;
    logic [SMW-1:0]  abs_re, abs_im;
    logic [NW-1:0]   nr_full, ni_full;
    logic [NW-1:0]   nr_top, ni_top;

    always_comb
    begin
        abs_re = n_re3_reg[SMW-1] ? SMW'(-n_re3_reg) : SMW'(n_re3_reg);
        abs_im = n_im3_reg[SMW-1] ? SMW'(-n_im3_reg) : SMW'(n_im3_reg);

        side_next.op    = op3_reg;
        side_next.neg_r = n_re3_reg[SMW-1];
        side_next.neg_i = n_im3_reg[SMW-1];
        side_next.mag_r = abs_re[MW-1:0];
        side_next.mag_i = abs_im[MW-1:0];
        side_next.den   = magb3_reg;
        side_next.mag_a = maga3_reg;
        side_next.s_re  = s_re3_reg;
        side_next.s_im  = s_im3_reg;
        side_next.s_sat = s_sat3_reg;
        side_next.s_ex  = s_ex3_reg;

        nr_full = {abs_re[MW-1:0], {F{1'b0}}};
        ni_full = {abs_im[MW-1:0], {F{1'b0}}};
        nr_top  = nr_full >> W;
        ni_top  = ni_full >> W;

        iter_next.rem_r = nr_top[MW-1:0];
        iter_next.rem_i = ni_top[MW-1:0];
        iter_next.q_r   = '0;
        iter_next.q_i   = '0;
        iter_next.sq    = '0;
        iter_next.srem  = '0;
    end

    logic       vl_reg   [0:W];
    side_t      side_reg [0:W];
    iter_t      iter_reg [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vl_reg[0] <= 1'b0;
        else
            vl_reg[0] <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        iter_reg[0] <= iter_next;
    end

    // steps: one quotient bit of each divider and one root bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_step
        localparam int BI = W - 1 - k;
        logic [NW-1:0] nr_k, ni_k;
        iter_t         it_next;

        assign nr_k = {side_reg[k].mag_r, {F{1'b0}}};
        assign ni_k = {side_reg[k].mag_i, {F{1'b0}}};

        cau_step #(
            .PART_WIDTH(W)
        ) u_step (
            .den       (side_reg[k].den),
            .rem_r_in  (iter_reg[k].rem_r),
            .q_r_in    (iter_reg[k].q_r),
            .bit_r     (nr_k[BI]),
            .rem_i_in  (iter_reg[k].rem_i),
            .q_i_in    (iter_reg[k].q_i),
            .bit_i     (ni_k[BI]),
            .srem_in   (iter_reg[k].srem),
            .sq_in     (iter_reg[k].sq),
            .pair      (side_reg[k].mag_a[2*BI +: 2]),
            .rem_r_out (it_next.rem_r),
            .q_r_out   (it_next.q_r),
            .rem_i_out (it_next.rem_i),
            .q_i_out   (it_next.q_i),
            .srem_out  (it_next.srem),
            .sq_out    (it_next.sq)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vl_reg[k+1] <= 1'b0;
            else
                vl_reg[k+1] <= vl_reg[k];
        end

        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
            iter_reg[k+1] <= it_next;
        end
    end

    // result select and clamp
    side_t         sd;
    iter_t         it;
    logic          ovf_r, ovf_i;
    logic [W:0]    dq_r, dq_i;
    logic [W:0]    cr, ci;
    logic          done_next;
    logic [W-1:0]  re_next, im_next;
    logic          lt_next, gt_next, eq_next, ex_next, dz_next, sat_next;

    assign sd = side_reg[W];
    assign it = iter_reg[W];

    always_comb
    begin
        ovf_r = CW'({sd.mag_r, {F{1'b0}}}) >= CW'({sd.den, {W{1'b0}}});
        ovf_i = CW'({sd.mag_i, {F{1'b0}}}) >= CW'({sd.den, {W{1'b0}}});
        dq_r  = ovf_r ? {1'b1, {W{1'b0}}} : {1'b0, it.q_r};
        dq_i  = ovf_i ? {1'b1, {W{1'b0}}} : {1'b0, it.q_i};

        cr       = '0;
        ci       = '0;
        lt_next  = 1'b0;
        gt_next  = 1'b0;
        eq_next  = 1'b0;
        ex_next  = 1'b0;
        dz_next  = 1'b0;
        re_next  = sd.s_re;
        im_next  = sd.s_im;
        sat_next = sd.s_sat;
        case (sd.op)
            OP_MUL:
            begin
                cr       = clamp_sm(sd.neg_r, (MW+1)'(sd.mag_r >> F));
                ci       = clamp_sm(sd.neg_i, (MW+1)'(sd.mag_i >> F));
                re_next  = cr[W-1:0];
                im_next  = ci[W-1:0];
                sat_next = cr[W] | ci[W];
            end
            OP_DIV:
            begin
                if (sd.den == '0)
                begin
                    dz_next  = 1'b1;
                    re_next  = '0;
                    im_next  = '0;
                    sat_next = 1'b0;
                end
                else
                begin
                    cr       = clamp_sm(sd.neg_r, (MW+1)'(dq_r));
                    ci       = clamp_sm(sd.neg_i, (MW+1)'(dq_i));
                    re_next  = cr[W-1:0];
                    im_next  = ci[W-1:0];
                    sat_next = cr[W] | ci[W];
                end
            end
            OP_MOD:
            begin
                cr       = clamp_sm(1'b0, (MW+1)'(it.sq));
                re_next  = cr[W-1:0];
                im_next  = '0;
                sat_next = cr[W];
            end
            OP_CMP:
            begin
                lt_next = sd.mag_a < sd.den;
                gt_next = sd.mag_a > sd.den;
                eq_next = sd.mag_a == sd.den;
                ex_next = sd.s_ex;
            end
            default:
            begin
            end
        endcase
        done_next = vl_reg[W];
    end

    logic         done_reg;
    logic [W-1:0] res_re_reg, res_im_reg;
    logic         lt_reg, gt_reg, eq_reg, ex_reg, dz_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= re_next;
        res_im_reg <= im_next;
        lt_reg     <= lt_next;
        gt_reg     <= gt_next;
        eq_reg     <= eq_next;
        ex_reg     <= ex_next;
        dz_reg     <= dz_next;
        sat_reg    <= sat_next;
    end

    assign done           = done_reg;
    assign res_re         = $signed(res_re_reg);
    assign res_im         = $signed(res_im_reg);
    assign mag_less       = lt_reg;
    assign mag_greater    = gt_reg;
    assign mag_equal      = eq_reg;
    assign exact_equal    = ex_reg;
    assign divide_by_zero = dz_reg;
    assign saturated      = sat_reg;

endmodule

// ===== hdl/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker #(
    parameter int PART_WIDTH = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [PART_WIDTH-1:0] res_re,
    input logic [PART_WIDTH-1:0] res_im,
    input logic                  mag_less,
    input logic                  mag_greater,
    input logic                  mag_equal,
    input logic                  divide_by_zero,
    input logic                  saturated
);

    localparam int LAT = PART_WIDTH + 5;

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("start beat not answered after pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching start beat");

    a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({mag_less, mag_greater, mag_equal}))
        else $error("magnitude flags not exclusive");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |->
            (res_re == '0) && (res_im == '0) && !saturated
            && !mag_less && !mag_greater && !mag_equal)
        else $error("divide by zero result not cleared");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .PART_WIDTH(PART_WIDTH)
) u_cau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .res_re         (res_re),
    .res_im         (res_im),
    .mag_less       (mag_less),
    .mag_greater    (mag_greater),
    .mag_equal      (mag_equal),
    .divide_by_zero (divide_by_zero),
    .saturated      (saturated)
);

// ===== tb/tb_complex_arithmetic_unit.sv =====
// Self-checking testbench for the fixed-point complex arithmetic unit.
module tb_complex_arithmetic_unit;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = 16;
    localparam int FB = 8;
    localparam int LATENCY = PW + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [PW-1:0] re;
        logic signed [PW-1:0] im;
        logic lt;
        logic gt;
        logic eq;
        logic ex;
        logic dz;
        logic sat;
    } cau_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [3:0] op;
    logic signed [PW-1:0] a_re, a_im, b_re, b_im;
    logic done;
    logic signed [PW-1:0] res_re, res_im;
    logic mag_less, mag_greater, mag_equal, exact_equal, divide_by_zero, saturated;

    cau_result_t pending_results[$];
    int  error_count;
    longint cycle_count;

    complex_arithmetic_unit #(.PART_WIDTH(PW), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .mag_less(mag_less),
        .mag_greater(mag_greater), .mag_equal(mag_equal),
        .exact_equal(exact_equal), .divide_by_zero(divide_by_zero),
        .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint clamp_part(longint v, inout logic sat);
        longint hi;
        hi = (longint'(1) << (PW - 1)) - 1;
        if (v > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        if (v < -hi - 1)
        begin
            sat = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    // signed quotient scaled by 2^FB, truncated toward zero, magnitude capped at 2^PW
    function automatic longint trunc_scaled_div(longint num, longint den);
        logic [127:0] q;
        logic [127:0] mag;
        mag = 128'((num < 0) ? -num : num);
        q = (mag << FB) / 128'(den);
        if (q > (128'd1 << PW))
            q = 128'd1 << PW;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint int_sqrt(longint s);
        longint root;
        longint t;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            t = root | (longint'(1) << i);
            if (t * t <= s)
                root = t;
        end
        return root;
    endfunction

    function automatic cau_result_t compute_result(logic [3:0] code, logic signed [PW-1:0] ar,
                                                   logic signed [PW-1:0] ai,
                                                   logic signed [PW-1:0] br,
                                                   logic signed [PW-1:0] bi);
        cau_result_t r;
        longint pr, pi, ma, mb;
        logic sat;
        r = '0;
        sat = 1'b0;
        case (code)
            OP_ADD:
            begin
                r.re = PW'(clamp_part(longint'(ar) + br, sat));
                r.im = PW'(clamp_part(longint'(ai) + bi, sat));
            end
            OP_SUB:
            begin
                r.re = PW'(clamp_part(longint'(ar) - br, sat));
                r.im = PW'(clamp_part(longint'(ai) - bi, sat));
            end
            OP_MUL:
            begin
                pr = longint'(ar) * br - longint'(ai) * bi;
                pi = longint'(ar) * bi + longint'(ai) * br;
                // truncate magnitude, not floor
                pr = (pr < 0) ? -((-pr) >>> FB) : (pr >>> FB);
                pi = (pi < 0) ? -((-pi) >>> FB) : (pi >>> FB);
                r.re = PW'(clamp_part(pr, sat));
                r.im = PW'(clamp_part(pi, sat));
            end
            OP_DIV:
            begin
                mb = longint'(br) * br + longint'(bi) * bi;
                if (mb == 0)
                    r.dz = 1'b1;
                else
                begin
                    pr = longint'(ar) * br + longint'(ai) * bi;
                    pi = longint'(ai) * br - longint'(ar) * bi;
                    r.re = PW'(clamp_part(trunc_scaled_div(pr, mb), sat));
                    r.im = PW'(clamp_part(trunc_scaled_div(pi, mb), sat));
                end
            end
            OP_CMP:
            begin
                ma = longint'(ar) * ar + longint'(ai) * ai;
                mb = longint'(br) * br + longint'(bi) * bi;
                r.lt = ma < mb;
                r.gt = ma > mb;
                r.eq = ma == mb;
                r.ex = (ar == br) && (ai == bi);
            end
            OP_MOD:
                r.re = PW'(clamp_part(int_sqrt(longint'(ar) * ar + longint'(ai) * ai), sat));
            OP_CONJ:
            begin
                r.re = ar;
                r.im = PW'(clamp_part(-longint'(ai), sat));
            end
            OP_INC:
            begin
                r.re = PW'(clamp_part(longint'(ar) + (longint'(1) << FB), sat));
                r.im = ai;
            end
            OP_DEC:
            begin
                r.re = PW'(clamp_part(longint'(ar) - (longint'(1) << FB), sat));
                r.im = ai;
            end
            default:
                ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cau_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (res_re !== want.re)          report_mismatch("res_re", res_re, want.re);
                if (res_im !== want.im)          report_mismatch("res_im", res_im, want.im);
                if (mag_less !== want.lt)        report_mismatch("mag_less", mag_less, want.lt);
                if (mag_greater !== want.gt)     report_mismatch("mag_greater", mag_greater, want.gt);
                if (mag_equal !== want.eq)       report_mismatch("mag_equal", mag_equal, want.eq);
                if (exact_equal !== want.ex)     report_mismatch("exact_equal", exact_equal, want.ex);
                if (divide_by_zero !== want.dz)  report_mismatch("divide_by_zero", divide_by_zero,
                                                                 want.dz);
                if (saturated !== want.sat)      report_mismatch("saturated", saturated, want.sat);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one beat: drive, hold until accepted, then drop start for a random gap only if keep_gap allows
    task automatic send_beat(logic [3:0] code, logic signed [PW-1:0] ar, logic signed [PW-1:0] ai,
                             logic signed [PW-1:0] br, logic signed [PW-1:0] bi, bit keep_gap);
        int gap;
        start <= 1'b1;
        op <= code;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(compute_result(code, ar, ai, br, bi));
        if (keep_gap && ($urandom_range(0, 1) == 1))
        begin
            gap = gap_length();
            if (gap > 0)
            begin
                start <= 1'b0;
                idle_cycles(gap);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [PW-1:0] rand_part();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return $urandom_range(0, 1) ? 16'sh0100 : -16'sh0100;
            4, 5: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [PW-1:0] corner[4];
        op_t code;
        corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0100};
        code = code.first();
        forever
        begin
            send_beat(code, corner[0], corner[1], corner[1], corner[0], 1'b0);
            send_beat(code, corner[1], corner[1], corner[3], corner[3], 1'b0);
            if (code == code.last())
                break;
            code = code.next();
        end
    endtask

    task automatic test_special_cases();
        send_beat(OP_DIV, 16'sh0500, -16'sh0300, 16'sh0000, 16'sh0000, 1'b0);
        send_beat(OP_DIV, 16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000, 1'b0);
        send_beat(OP_CONJ, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0);
        send_beat(OP_CMP, 16'sh0300, 16'sh0400, 16'sh0300, 16'sh0400, 1'b0);
        send_beat(OP_CMP, 16'sh0300, 16'sh0400, -16'sh0400, 16'sh0300, 1'b0);
        send_beat(4'd9, 16'sh0101, 16'sh0101, 16'sh0101, 16'sh0101, 1'b0);
        send_beat(4'd15, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
    endtask

    task automatic test_random_ops(int count);
        logic [3:0] code;
        for (int i = 0; i < count; i++)
        begin
            code = ($urandom_range(0, 39) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
            send_beat(code, rand_part(), rand_part(), rand_part(), rand_part(), 1'b1);
            // occasional long run back to back
            if (i % 200 == 100)
                for (int k = 0; k < 30; k++)
                    send_beat(4'($urandom_range(0, 8)), rand_part(), rand_part(), rand_part(),
                              rand_part(), 1'b0);
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = '0;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        idle_cycles(6);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special_cases();
        start <= 1'b0;
        wait_drained();
        test_random_ops(600);
        start <= 1'b0;
        wait_drained();
        test_random_ops(560);
        start <= 1'b0;
        wait_drained();
        idle_cycles(LATENCY + 10);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
